// File: rtl/core/dcp_pkg.sv
package dcp_pkg;

    // item command codes
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_BLOCK = 2'd2;

    // port offsets
    localparam logic [3:0] PORT_MIX_ADDR = 4'h4;
    localparam logic [3:0] PORT_MIX_DATA = 4'h5;
    localparam logic [3:0] PORT_RESET    = 4'h6;
    localparam logic [3:0] PORT_RD_DATA  = 4'hA;
    localparam logic [3:0] PORT_DSP      = 4'hC;
    localparam logic [3:0] PORT_RD_STAT  = 4'hE;
    localparam logic [3:0] PORT_ACK16    = 4'hF;

    // config register indexes
    localparam logic CFG_VER_MAJOR = 1'b0;
    localparam logic CFG_VER_MINOR = 1'b1;

    // dsp opcodes
    localparam logic [7:0] OP_VERSION   = 8'hE1;
    localparam logic [7:0] OP_TIME_CONST = 8'h40;
    localparam logic [7:0] OP_RATE_OUT  = 8'h41;
    localparam logic [7:0] OP_RATE_IN   = 8'h42;
    localparam logic [7:0] OP_BLOCK_SIZE = 8'h48;
    localparam logic [7:0] OP_SC8_A     = 8'h14;
    localparam logic [7:0] OP_SC8_B     = 8'h91;
    localparam logic [7:0] OP_AI8_A     = 8'h1C;
    localparam logic [7:0] OP_AI8_B     = 8'h90;
    localparam logic [7:0] OP_PAUSE_A   = 8'hD0;
    localparam logic [7:0] OP_PAUSE_B   = 8'hD5;
    localparam logic [7:0] OP_RESUME_A  = 8'hD4;
    localparam logic [7:0] OP_RESUME_B  = 8'hD6;
    localparam logic [7:0] OP_EXIT_AI_A = 8'hD9;
    localparam logic [7:0] OP_EXIT_AI_B = 8'hDA;
    localparam logic [7:0] OP_SPK_ON    = 8'hD1;
    localparam logic [7:0] OP_SPK_OFF   = 8'hD3;
    localparam logic [7:0] OP_DIRECT    = 8'h10;
    localparam logic [7:0] OP_SILENCE   = 8'h80;
    localparam logic [7:0] OP_GEN_LO    = 8'hB0;
    localparam logic [7:0] OP_GEN_HI    = 8'hCF;

    // misc constants
    localparam logic [7:0]  RESET_ACK    = 8'hAA;
    localparam logic [7:0]  IDLE_BYTE    = 8'hFF;
    localparam logic [7:0]  STAT_READY   = 8'h7F;
    localparam logic [7:0]  MIX_IDX_80   = 8'h80;
    localparam logic [7:0]  MIX_IDX_81   = 8'h81;
    localparam logic [7:0]  MIX_IDX_IRQ  = 8'h82;
    localparam logic [7:0]  MIX_IDX_OUT  = 8'h0E;
    localparam logic [7:0]  MIX_VAL_80   = 8'h02;
    localparam logic [7:0]  MIX_VAL_81   = 8'h22;
    localparam logic [19:0] DEFAULT_RATE = 20'd11025;
    localparam logic [19:0] TC_CLOCK     = 20'd1000000;

    typedef struct packed {
        logic capture;
        logic exec;
        logic push2;
        logic div_load;
    } t_dp_cmd;

    typedef struct packed {
        logic need_push2;
        logic need_div;
        logic div_done;
    } t_dp_stat;

    function automatic logic [1:0] arg_count(input logic [7:0] c);
        logic [1:0] n;
        n = 2'd0;
        if (c >= OP_GEN_LO && c <= OP_GEN_HI) begin
            n = 2'd3;
        end else if (c == OP_SC8_A || c == OP_SC8_B || c == OP_RATE_OUT ||
                     c == OP_RATE_IN || c == OP_BLOCK_SIZE || c == OP_SILENCE) begin
            n = 2'd2;
        end else if (c == OP_TIME_CONST || c == OP_DIRECT) begin
            n = 2'd1;
        end
        return n;
    endfunction

endpackage

// File: rtl/core/dcp_divider.sv
module dcp_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [8:0]  i_divisor,
    output logic        o_done,
    output logic [19:0] o_quot
);

    // restoring division of the fixed clock by the divisor, one bit a cycle
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [19:0] r_dvd;
    logic [19:0] r_quot;
    logic [9:0]  r_rem;
    logic [8:0]  r_dvs;
    logic [9:0]  w_shift;
    logic        w_ge;

    assign w_shift = {r_rem[8:0], r_dvd[19]};
    assign w_ge    = w_shift >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd19;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= dcp_pkg::TC_CLOCK;
            r_dvs  <= i_divisor;
            r_rem  <= 10'd0;
            r_quot <= 20'd0;
        end else if (r_busy) begin
            r_dvd  <= {r_dvd[18:0], 1'b0};
            r_rem  <= w_ge ? (w_shift - {1'b0, r_dvs}) : w_shift;
            r_quot <= {r_quot[18:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: rtl/core/dcp_ctrl.sv
module dcp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  dcp_pkg::t_dp_stat i_stat,
    output dcp_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_PUSH2 = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_EXEC;
            S_EXEC: begin
                if (i_stat.need_push2)    n_state = S_PUSH2;
                else if (i_stat.need_div) n_state = S_DIV;
                else                      n_state = S_DONE;
            end
            S_PUSH2: n_state = S_DONE;
            S_DIV:   if (i_stat.div_done) n_state = S_DONE;
            S_DONE:  if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready     = r_state == S_IDLE;
    assign o_out_valid    = r_state == S_DONE;
    assign o_cmd.capture  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec     = r_state == S_EXEC;
    assign o_cmd.push2    = r_state == S_PUSH2;
    assign o_cmd.div_load = (r_state == S_DIV) && i_stat.div_done;

endmodule

// File: rtl/core/dcp_datapath.sv
module dcp_datapath #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dcp_pkg::t_dp_cmd  i_cmd,
    output dcp_pkg::t_dp_stat o_stat,
    input  logic [1:0]        i_command,
    input  logic [3:0]        i_port_offset,
    input  logic [7:0]        i_write_data,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [7:0]        i_cfg_data,
    output logic [7:0]        o_read_data,
    output logic              o_start_pulse,
    output logic              o_sixteen_bit,
    output logic              o_stereo_mode,
    output logic              o_signed_samples,
    output logic              o_auto_init,
    output logic [18:0]       o_block_length,
    output logic [19:0]       o_sample_rate,
    output logic              o_playing,
    output logic              o_paused,
    output logic              o_speaker_on,
    output logic              o_irq_pulse
);

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam logic [PW-1:0] LAST = PW'(FIFO_DEPTH - 1);

    function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
        return (p == LAST) ? '0 : p + PW'(1);
    endfunction

    // memories
    logic [7:0] fifo_mem [FIFO_DEPTH];
    logic [7:0] mix_mem  [256];
    logic [255:0] r_mix_vld;

    // latched item
    logic [1:0] r_in_cmd;
    logic [3:0] r_in_port;
    logic [7:0] r_in_data;
    logic [7:0] r_mix_rd;
    logic       r_mix_rv;
    logic [7:0] r_fifo_rd;

    // block state
    logic [7:0]    r_ver_major, r_ver_minor;
    logic [PW-1:0] r_head, n_head, r_tail, n_tail;
    logic          r_armed, n_armed;
    logic [7:0]    r_mix_idx, n_mix_idx;
    logic [7:0]    r_mix_out, n_mix_out;
    logic [7:0]    r_pend, n_pend;
    logic [7:0]    r_arg [3];
    logic [7:0]    n_arg [3];
    logic [1:0]    r_seen, n_seen, r_need, n_need;
    logic [19:0]   r_prate, n_prate, r_arate, n_arate;
    logic [16:0]   r_pblock, n_pblock;
    logic [18:0]   r_ablock, n_ablock;
    logic          r_f16, n_f16, r_fst, n_fst, r_fsg, n_fsg, r_fau, n_fau;
    logic          r_play, n_play, r_pause, n_pause, r_spk, n_spk;
    logic          r_irq8, n_irq8, r_irq16, n_irq16;
    logic [7:0]    r_rd, n_rd;
    logic          r_start, n_start, r_irq, n_irq;

    logic          fifo_we;
    logic [PW-1:0] fifo_waddr;
    logic [7:0]    fifo_wdata;
    logic          mix_we;
    logic          c_div, c_push2;
    logic [8:0]    div_dvs;
    logic          div_done;
    logic [19:0]   div_q;

    dcp_divider u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.exec && c_div),
        .i_divisor (div_dvs),
        .o_done    (div_done),
        .o_quot    (div_q)
    );

    always_comb begin
        logic       run;
        logic [7:0] op;
        logic       bt, bt16, btst, btsg, btau;
        logic [18:0] btlen;
        logic [16:0] len;

        n_head = r_head;   n_tail = r_tail;   n_armed = r_armed;
        n_mix_idx = r_mix_idx; n_mix_out = r_mix_out;
        n_pend = r_pend;   n_arg = r_arg;     n_seen = r_seen;  n_need = r_need;
        n_prate = r_prate; n_arate = r_arate; n_pblock = r_pblock; n_ablock = r_ablock;
        n_f16 = r_f16; n_fst = r_fst; n_fsg = r_fsg; n_fau = r_fau;
        n_play = r_play; n_pause = r_pause; n_spk = r_spk;
        n_irq8 = r_irq8; n_irq16 = r_irq16;
        n_rd = r_rd; n_start = r_start; n_irq = r_irq;
        fifo_we = 1'b0; fifo_waddr = r_head; fifo_wdata = r_ver_major;
        mix_we = 1'b0; c_div = 1'b0; c_push2 = 1'b0;
        run = 1'b0; op = r_in_data;
        bt = 1'b0; bt16 = 1'b0; btst = r_mix_out[1]; btsg = 1'b0; btau = 1'b0;
        btlen = 19'd1; len = 17'd1;

        if (i_cmd.exec) begin
            n_rd = dcp_pkg::IDLE_BYTE; n_start = 1'b0; n_irq = 1'b0;
            case (r_in_cmd)
                dcp_pkg::CMD_READ: begin
                    case (r_in_port)
                        dcp_pkg::PORT_MIX_DATA: begin
                            if (r_mix_idx == dcp_pkg::MIX_IDX_80)
                                n_rd = dcp_pkg::MIX_VAL_80;
                            else if (r_mix_idx == dcp_pkg::MIX_IDX_81)
                                n_rd = dcp_pkg::MIX_VAL_81;
                            else if (r_mix_idx == dcp_pkg::MIX_IDX_IRQ)
                                n_rd = {6'd0, r_irq16, r_irq8};
                            else
                                n_rd = r_mix_rv ? r_mix_rd : 8'd0;
                        end
                        dcp_pkg::PORT_RD_DATA: begin
                            if (r_head != r_tail) begin
                                n_rd   = r_fifo_rd;
                                n_tail = nxt(r_tail);
                            end
                        end
                        dcp_pkg::PORT_DSP: n_rd = dcp_pkg::STAT_READY;
                        dcp_pkg::PORT_RD_STAT: begin
                            n_irq8 = 1'b0;
                            n_rd = (r_head == r_tail) ? dcp_pkg::STAT_READY
                                                      : dcp_pkg::IDLE_BYTE;
                        end
                        dcp_pkg::PORT_ACK16: n_irq16 = 1'b0;
                        default: ;
                    endcase
                end
                dcp_pkg::CMD_WRITE: begin
                    case (r_in_port)
                        dcp_pkg::PORT_MIX_ADDR: n_mix_idx = r_in_data;
                        dcp_pkg::PORT_MIX_DATA: begin
                            mix_we = 1'b1;
                            if (r_mix_idx == dcp_pkg::MIX_IDX_OUT) n_mix_out = r_in_data;
                        end
                        dcp_pkg::PORT_RESET: begin
                            if (r_in_data[0]) begin
                                n_armed = 1'b1;
                            end else if (r_armed) begin
                                n_armed = 1'b0;
                                n_tail = '0;
                                fifo_we = 1'b1;
                                fifo_waddr = '0;
                                fifo_wdata = dcp_pkg::RESET_ACK;
                                n_head = nxt('0);
                                n_play = 1'b0; n_pause = 1'b0; n_spk = 1'b1;
                                n_seen = 2'd0; n_need = 2'd0;
                                n_irq8 = 1'b0; n_irq16 = 1'b0;
                            end
                        end
                        dcp_pkg::PORT_DSP: begin
                            if (r_need != 2'd0) begin
                                case (r_seen)
                                    2'd0:    n_arg[0] = r_in_data;
                                    2'd1:    n_arg[1] = r_in_data;
                                    2'd2:    n_arg[2] = r_in_data;
                                    default: ;
                                endcase
                                n_seen = r_seen + 2'd1;
                                if (n_seen >= r_need) begin
                                    n_need = 2'd0;
                                    run = 1'b1;
                                    op = r_pend;
                                end
                            end else begin
                                n_pend = r_in_data;
                                n_seen = 2'd0;
                                n_need = dcp_pkg::arg_count(r_in_data);
                                run = n_need == 2'd0;
                            end
                        end
                        default: ;
                    endcase
                end
                dcp_pkg::CMD_BLOCK: begin
                    if (r_play && !r_pause) begin
                        if (r_f16) n_irq16 = 1'b1;
                        else       n_irq8 = 1'b1;
                        n_irq = 1'b1;
                        if (!r_fau) n_play = 1'b0;
                    end
                end
                default: ;
            endcase

            if (run) begin
                case (op)
                    dcp_pkg::OP_VERSION: begin
                        c_push2 = 1'b1;
                        if (nxt(r_head) != r_tail) begin
                            fifo_we = 1'b1;
                            n_head  = nxt(r_head);
                        end
                    end
                    dcp_pkg::OP_TIME_CONST: c_div = 1'b1;
                    dcp_pkg::OP_RATE_OUT, dcp_pkg::OP_RATE_IN:
                        n_prate = {4'd0, n_arg[0], n_arg[1]};
                    dcp_pkg::OP_BLOCK_SIZE:
                        n_pblock = {1'b0, n_arg[1], n_arg[0]} + 17'd1;
                    dcp_pkg::OP_SC8_A, dcp_pkg::OP_SC8_B: begin
                        bt = 1'b1;
                        btlen = {2'd0, {1'b0, n_arg[1], n_arg[0]} + 17'd1};
                    end
                    dcp_pkg::OP_AI8_A, dcp_pkg::OP_AI8_B: begin
                        bt = 1'b1; btau = 1'b1; btlen = {2'd0, r_pblock};
                    end
                    dcp_pkg::OP_PAUSE_A, dcp_pkg::OP_PAUSE_B:   n_pause = 1'b1;
                    dcp_pkg::OP_RESUME_A, dcp_pkg::OP_RESUME_B: n_pause = 1'b0;
                    dcp_pkg::OP_EXIT_AI_A, dcp_pkg::OP_EXIT_AI_B: n_fau = 1'b0;
                    dcp_pkg::OP_SPK_ON:  n_spk = 1'b1;
                    dcp_pkg::OP_SPK_OFF: n_spk = 1'b0;
                    default: begin
                        // generic 8/16-bit start, input direction ignored
                        if (op inside {[dcp_pkg::OP_GEN_LO:dcp_pkg::OP_GEN_HI]} && !op[3]) begin
                            bt = 1'b1;
                            bt16 = op[4];
                            btst = n_arg[0][5];
                            btsg = n_arg[0][4];
                            btau = op[2];
                            len = {1'b0, n_arg[2], n_arg[1]} + 17'd1;
                            btlen = {2'd0, len} << ({1'b0, bt16} + {1'b0, btst});
                        end
                    end
                endcase
            end

            if (bt) begin
                n_f16 = bt16; n_fst = btst; n_fsg = btsg; n_fau = btau;
                n_play = 1'b1; n_pause = 1'b0;
                n_ablock = btlen;
                n_arate = (r_prate != 20'd0) ? r_prate : dcp_pkg::DEFAULT_RATE;
                n_start = 1'b1;
            end
        end

        if (i_cmd.push2) begin
            fifo_wdata = r_ver_minor;
            if (nxt(r_head) != r_tail) begin
                fifo_we = 1'b1;
                n_head  = nxt(r_head);
            end
        end

        if (i_cmd.div_load) n_prate = div_q;
    end

    assign div_dvs = 9'd256 - {1'b0, n_arg[0]};

    always_ff @(posedge i_clk) begin
        if (fifo_we) fifo_mem[fifo_waddr] <= fifo_wdata;
        if (mix_we)  mix_mem[r_mix_idx] <= r_in_data;
        if (i_cmd.capture) begin
            r_mix_rd  <= mix_mem[r_mix_idx];
            r_mix_rv  <= r_mix_vld[r_mix_idx];
            r_fifo_rd <= fifo_mem[r_tail];
            r_in_cmd  <= i_command;
            r_in_port <= i_port_offset;
            r_in_data <= i_write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mix_vld <= '0;
            r_ver_major <= 8'd4; r_ver_minor <= 8'd5;
            r_head <= '0; r_tail <= '0; r_armed <= 1'b0;
            r_mix_idx <= 8'd0; r_mix_out <= 8'd0;
            r_pend <= 8'd0; r_arg <= '{default: 8'd0};
            r_seen <= 2'd0; r_need <= 2'd0;
            r_prate <= dcp_pkg::DEFAULT_RATE; r_arate <= dcp_pkg::DEFAULT_RATE;
            r_pblock <= 17'd1; r_ablock <= 19'd1;
            r_f16 <= 1'b0; r_fst <= 1'b0; r_fsg <= 1'b0; r_fau <= 1'b0;
            r_play <= 1'b0; r_pause <= 1'b0; r_spk <= 1'b1;
            r_irq8 <= 1'b0; r_irq16 <= 1'b0;
            r_rd <= dcp_pkg::IDLE_BYTE; r_start <= 1'b0; r_irq <= 1'b0;
        end else begin
            if (mix_we) r_mix_vld[r_mix_idx] <= 1'b1;
            if (i_cfg_we) begin
                if (i_cfg_idx == dcp_pkg::CFG_VER_MAJOR) r_ver_major <= i_cfg_data;
                else                                     r_ver_minor <= i_cfg_data;
            end
            r_head <= n_head; r_tail <= n_tail; r_armed <= n_armed;
            r_mix_idx <= n_mix_idx; r_mix_out <= n_mix_out;
            r_pend <= n_pend; r_arg <= n_arg; r_seen <= n_seen; r_need <= n_need;
            r_prate <= n_prate; r_arate <= n_arate;
            r_pblock <= n_pblock; r_ablock <= n_ablock;
            r_f16 <= n_f16; r_fst <= n_fst; r_fsg <= n_fsg; r_fau <= n_fau;
            r_play <= n_play; r_pause <= n_pause; r_spk <= n_spk;
            r_irq8 <= n_irq8; r_irq16 <= n_irq16;
            r_rd <= n_rd; r_start <= n_start; r_irq <= n_irq;
        end
    end

    assign o_stat.need_push2 = c_push2;
    assign o_stat.need_div   = c_div;
    assign o_stat.div_done   = div_done;

    assign o_read_data      = r_rd;
    assign o_start_pulse    = r_start;
    assign o_sixteen_bit    = r_f16;
    assign o_stereo_mode    = r_fst;
    assign o_signed_samples = r_fsg;
    assign o_auto_init      = r_fau;
    assign o_block_length   = r_ablock;
    assign o_sample_rate    = r_arate;
    assign o_playing        = r_play;
    assign o_paused         = r_pause;
    assign o_speaker_on     = r_spk;
    assign o_irq_pulse      = r_irq;

endmodule

// File: rtl/core/dsp_command_port_device.sv
// dsp command port block: each item is one bus read, one bus write or one
// block-done event, and gives exactly one result item with the read byte and
// the playback state after it. one item at a time: capture (also the
// registered mixer and fifo read), execute, then the result waits in the
// output register until taken. the version command adds a state for its
// second fifo push (single write port). a time constant command runs the
// restoring divider for 1000000 / (256 - tc) and loads the quotient as the
// divider finishes, before the result is offered.
// there is no clearing pass: mixer entries carry valid bits cleared by reset.
// config writes take effect at once and must be done while idle.
module dsp_command_port_device #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [3:0]  i_port_offset,
    input  logic [7:0]  i_write_data,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    output logic        o_start_pulse,
    output logic        o_sixteen_bit,
    output logic        o_stereo_mode,
    output logic        o_signed_samples,
    output logic        o_auto_init,
    output logic [18:0] o_block_length,
    output logic [19:0] o_sample_rate,
    output logic        o_playing,
    output logic        o_paused,
    output logic        o_speaker_on,
    output logic        o_irq_pulse,
    // config write port: index 0 version major, 1 version minor
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    dcp_pkg::t_dp_cmd  w_cmd;
    dcp_pkg::t_dp_stat w_stat;

    // sequencer
    dcp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // state, fifo, mixer store and divider
    dcp_datapath #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_command        (i_command),
        .i_port_offset    (i_port_offset),
        .i_write_data     (i_write_data),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_read_data      (o_read_data),
        .o_start_pulse    (o_start_pulse),
        .o_sixteen_bit    (o_sixteen_bit),
        .o_stereo_mode    (o_stereo_mode),
        .o_signed_samples (o_signed_samples),
        .o_auto_init      (o_auto_init),
        .o_block_length   (o_block_length),
        .o_sample_rate    (o_sample_rate),
        .o_playing        (o_playing),
        .o_paused         (o_paused),
        .o_speaker_on     (o_speaker_on),
        .o_irq_pulse      (o_irq_pulse)
    );

endmodule
